FILE: rtl/sblm_pkg.sv
package sblm_pkg;

   // Field widths
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int BANK_W  = 5;
   localparam int COUNT_W = 6;

   // Serial divider: one remainder bit per step over a bank-number dividend
   localparam int DIV_STEPS  = BANK_W;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   // Configuration register indexes
   localparam logic [1:0] CSR_PRG_BANKS = 2'd0;
   localparam logic [1:0] CSR_CHR_BANKS = 2'd1;
   localparam logic [1:0] CSR_CHR_RAM   = 2'd2;

   // Configuration reset values
   localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 6'd8;
   localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 6'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 6'd32;

   // Commit targets, taken from address bits 14:13
   localparam logic [1:0] TGT_CONTROL = 2'd0;
   localparam logic [1:0] TGT_CHR0    = 2'd1;
   localparam logic [1:0] TGT_CHR1    = 2'd2;
   localparam logic [1:0] TGT_PRG     = 2'd3;

   // Program banking modes, control bits 3:2
   localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
   localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
   localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

   // Control register constants
   localparam logic [BANK_W-1:0] CONTROL_RESET   = 5'h0C;
   localparam logic [BANK_W-1:0] CTRL_RESET_BITS = 5'h0C;

   // Index of the write that completes a serial load
   localparam logic [2:0] LOAD_LAST = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] cpu_address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [BANK_W-1:0] prg_low_bank;
      logic [BANK_W-1:0] prg_high_bank;
      logic [BANK_W-1:0] chr_low_bank;
      logic [BANK_W-1:0] chr_high_bank;
      logic [1:0]        mirroring;
      logic              nmi_hold;
      logic              committed;
      logic [1:0]        target;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

endpackage

FILE: rtl/sblm_ctrl.sv
module sblm_ctrl
   import sblm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_STEP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_STEPS - 1);

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Decode commands from the current state
   always_comb begin
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.load   = (state_ff == ST_LOAD);
      cmd.step   = (state_ff == ST_STEP);
      cmd.finish = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one transaction: capture, load divider, step, write result
   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            step_cnt_in = '0;
            state_in    = ST_STEP;
         end
         ST_STEP: begin
            if (step_cnt_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (cmd.finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result valid until the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

   // An accepted transaction always moves on to the divider load
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.load)
      else $error("accept not followed by divider load");

   // A waiting result stays valid until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

endmodule

FILE: rtl/sblm_dp.sv
module sblm_dp
   import sblm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  req_type            req_payload,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [COUNT_W-1:0] csr_wdata,
   output rsp_type            rsp_payload
);

   localparam int LANES = 3;
   localparam int LANE_PRG  = 0;
   localparam int LANE_CHR0 = 1;
   localparam int LANE_CHR1 = 2;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] r;
      r = n;
      if (n == '0) r = COUNT_W'(1);
      else if (n > COUNT_MAX) r = COUNT_MAX;
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] half_count(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] h;
      h = {1'b0, n[COUNT_W-1:1]};
      if (h == '0) h = COUNT_W'(1);
      return h;
   endfunction

   // Configuration
   logic [COUNT_W-1:0] prg_count_ff, prg_count_in;
   logic [COUNT_W-1:0] chr_count_ff, chr_count_in;
   logic               chr_ram_ff, chr_ram_in;

   // Loader and mapper registers
   logic [BANK_W-1:0] shift_ff, shift_in;
   logic [2:0]        wcount_ff, wcount_in;
   logic [BANK_W-1:0] control_ff, control_in;
   logic [BANK_W-1:0] chr0_ff, chr0_in;
   logic [BANK_W-1:0] chr1_ff, chr1_in;
   logic [BANK_W-1:0] prg_bank_ff, prg_bank_in;
   logic              nmi_ff, nmi_in;
   logic              committed_ff, committed_in;
   logic [1:0]        target_ff, target_in;
   logic [BANK_W-1:0] shifted;
   logic [1:0]        addr_target;

   // Divider lanes
   logic [BANK_W-1:0]  dvd_ff [LANES];
   logic [BANK_W-1:0]  dvd_in [LANES];
   logic [COUNT_W-1:0] dvs_ff [LANES];
   logic [COUNT_W-1:0] dvs_in [LANES];
   logic [BANK_W-1:0]  rem_ff [LANES];
   logic [BANK_W-1:0]  rem_in [LANES];

   rsp_type rsp_ff, rsp_in;

   logic [COUNT_W-1:0] n_prg, h_prg, n_chr, h_chr;
   logic [1:0]         prg_mode;
   logic               prg_wide;
   logic               chr_4k;

   assign n_prg    = clamp_count(prg_count_ff);
   assign h_prg    = half_count(n_prg);
   assign n_chr    = clamp_count(chr_count_ff);
   assign h_chr    = half_count(n_chr);
   assign prg_mode = control_ff[3:2];
   assign prg_wide = (prg_mode == PRG_MODE_32K_A) || (prg_mode == PRG_MODE_32K_B);
   assign chr_4k   = control_ff[4];

   // Take configuration writes
   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      chr_ram_in   = chr_ram_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PRG_BANKS: prg_count_in = csr_wdata;
            CSR_CHR_BANKS: chr_count_in = csr_wdata;
            CSR_CHR_RAM:   chr_ram_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Shift in the serial bit, commit on the fifth write, clear on bit 7
   always_comb begin
      shift_in     = shift_ff;
      wcount_in    = wcount_ff;
      control_in   = control_ff;
      chr0_in      = chr0_ff;
      chr1_in      = chr1_ff;
      prg_bank_in  = prg_bank_ff;
      nmi_in       = nmi_ff;
      committed_in = committed_ff;
      target_in    = target_ff;
      shifted      = {req_payload.write_data[0], shift_ff[BANK_W-1:1]};
      addr_target  = req_payload.cpu_address[14:13];
      if (cmd.accept) begin
         committed_in = 1'b0;
         target_in    = TGT_CONTROL;
         if (req_payload.write_data[7]) begin
            shift_in   = '0;
            wcount_in  = '0;
            control_in = control_ff | CTRL_RESET_BITS;
            nmi_in     = 1'b0;
         end else begin
            if (wcount_ff == '0) nmi_in = 1'b1;
            if (wcount_ff == LOAD_LAST) begin
               committed_in = 1'b1;
               target_in    = addr_target;
               case (addr_target)
                  TGT_CONTROL: control_in  = shifted;
                  TGT_CHR0:    chr0_in     = shifted;
                  TGT_CHR1:    chr1_in     = shifted;
                  default:     prg_bank_in = shifted;
               endcase
               shift_in  = '0;
               wcount_in = '0;
               nmi_in    = 1'b0;
            end else begin
               shift_in  = shifted;
               wcount_in = wcount_ff + 3'd1;
            end
         end
      end
   end

   // Load the divider lanes, then advance one remainder bit per step
   always_comb begin
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         dvd_in[LANE_PRG]  = prg_wide ? {2'b00, prg_bank_ff[3:1]} : {1'b0, prg_bank_ff[3:0]};
         dvs_in[LANE_PRG]  = prg_wide ? h_prg : n_prg;
         dvd_in[LANE_CHR0] = chr_4k ? chr0_ff : {1'b0, chr0_ff[BANK_W-1:1]};
         dvs_in[LANE_CHR0] = chr_4k ? n_chr : h_chr;
         dvd_in[LANE_CHR1] = chr1_ff;
         dvs_in[LANE_CHR1] = n_chr;
         for (int i = 0; i < LANES; i++) rem_in[i] = '0;
      end else if (cmd.step) begin
         for (int i = 0; i < LANES; i++) begin
            if ({rem_ff[i], dvd_ff[i][BANK_W-1]} >= dvs_ff[i]) begin
               rem_in[i] = BANK_W'({rem_ff[i], dvd_ff[i][BANK_W-1]} - dvs_ff[i]);
            end else begin
               rem_in[i] = rem_ff[i];
               rem_in[i] = {rem_ff[i][BANK_W-2:0], dvd_ff[i][BANK_W-1]};
            end
            dvd_in[i] = {dvd_ff[i][BANK_W-2:0], 1'b0};
         end
      end
   end

   // Form the bank outputs from the remainders, counts, modes and RAM flag; capture status
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         case (prg_mode)
            PRG_MODE_FIX_FIRST: begin
               rsp_in.prg_low_bank  = '0;
               rsp_in.prg_high_bank = rem_ff[LANE_PRG];
            end
            PRG_MODE_FIX_LAST: begin
               rsp_in.prg_low_bank  = rem_ff[LANE_PRG];
               rsp_in.prg_high_bank = BANK_W'(n_prg - COUNT_W'(1));
            end
            default: begin
               rsp_in.prg_low_bank  = {rem_ff[LANE_PRG][BANK_W-2:0], 1'b0};
               rsp_in.prg_high_bank = (n_prg == COUNT_W'(1)) ? '0
                                    : {rem_ff[LANE_PRG][BANK_W-2:0], 1'b1};
            end
         endcase
         if (chr_ram_ff) begin
            rsp_in.chr_low_bank  = BANK_W'(0);
            rsp_in.chr_high_bank = BANK_W'(1);
         end else if (chr_4k) begin
            rsp_in.chr_low_bank  = rem_ff[LANE_CHR0];
            rsp_in.chr_high_bank = rem_ff[LANE_CHR1];
         end else begin
            rsp_in.chr_low_bank  = {rem_ff[LANE_CHR0][BANK_W-2:0], 1'b0};
            rsp_in.chr_high_bank = (n_chr == COUNT_W'(1)) ? '0
                                 : {rem_ff[LANE_CHR0][BANK_W-2:0], 1'b1};
         end
         rsp_in.mirroring = control_ff[1:0];
         rsp_in.nmi_hold  = nmi_ff;
         rsp_in.committed = committed_ff;
         rsp_in.target    = target_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= PRG_COUNT_RESET;
         chr_count_ff <= CHR_COUNT_RESET;
         chr_ram_ff   <= 1'b0;
         shift_ff     <= '0;
         wcount_ff    <= '0;
         control_ff   <= CONTROL_RESET;
         chr0_ff      <= '0;
         chr1_ff      <= '0;
         prg_bank_ff  <= '0;
         nmi_ff       <= 1'b0;
         committed_ff <= 1'b0;
         target_ff    <= TGT_CONTROL;
      end else begin
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
         chr_ram_ff   <= chr_ram_in;
         shift_ff     <= shift_in;
         wcount_ff    <= wcount_in;
         control_ff   <= control_in;
         chr0_ff      <= chr0_in;
         chr1_ff      <= chr1_in;
         prg_bank_ff  <= prg_bank_in;
         nmi_ff       <= nmi_in;
         committed_ff <= committed_in;
         target_ff    <= target_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   // The loader never counts past the committing write
   assert property (@(posedge clock) disable iff (reset)
      wcount_ff <= LOAD_LAST)
      else $error("serial write count out of range");

   // A commit always releases the NMI hold
   assert property (@(posedge clock) disable iff (reset)
      committed_ff |-> !nmi_ff)
      else $error("NMI hold still raised after commit");

   // A commit always clears the loader
   assert property (@(posedge clock) disable iff (reset)
      committed_ff |-> (wcount_ff == '0))
      else $error("loader not cleared after commit");

endmodule

FILE: rtl/serial_loaded_bank_mapper.sv
// Serially loaded bank mapper. Each transaction on the req_ channel is one CPU
// write: data bit 7 clears the five-bit serial loader, otherwise data bit 0 is
// shifted in and the fifth write commits the value to the register chosen by
// address bits 14:13. Every write yields one rsp_ transaction carrying the
// current program and character banks, the mirroring mode, the NMI hold flag
// and the commit status. Bank numbers are reduced modulo the bank counts set
// through the csr_ port (index 0 program 16KB banks, 1 character 4KB banks,
// 2 character RAM flag); write the csr_ port only while no transaction is in
// flight. The mapper registers update on the accepting edge; then the
// remainder lanes are loaded, the bit-serial modulo unit steps once per
// bank-number bit and the output register is written, after which req_ready
// returns. A write takes longer while an unread result holds the block in
// its last state. The next write is accepted while a result waits in the
// output register.
module serial_loaded_bank_mapper
   import sblm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [COUNT_W-1:0] csr_wdata
);

   cmd_type cmd;

   sblm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sblm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule
